// File: rtl/ylpc_pkg.sv
package ylpc_pkg;

  // Table geometry: one axis per 4-bit component
  localparam int LEVELS_PER_AXIS = 16;
  localparam int NIBBLE_W        = $clog2(LEVELS_PER_AXIS);
  localparam int TABLE_DEPTH     = LEVELS_PER_AXIS * LEVELS_PER_AXIS * LEVELS_PER_AXIS;
  localparam int TABLE_AW        = $clog2(TABLE_DEPTH);
  localparam int CLASS_W         = 3;

  // Overlay colour registers
  localparam int COLOR_W        = 24;
  localparam int CHAN_W         = 8;
  localparam int NUM_COLOR_REGS = 7;
  localparam int CFG_IDX_W      = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_CLASS1_COLOR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLASS7_COLOR = 3'd6;

  typedef logic [NUM_COLOR_REGS-1:0][COLOR_W-1:0] color_bank_t;

  localparam color_bank_t COLOR_RESET = {
    24'h00FF00, 24'h0000FF, 24'hFFFFFF, 24'h800080,
    24'h808000, 24'hFF0000, 24'h00FFFF
  };

  // Item kind carried on tuser
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_PIXEL = 1'b1;

  localparam logic [NIBBLE_W-1:0] MID_CHROMA = 4'd8;

  // Conversion: every term scaled by 2000/16, so floor(w / 125) is the channel
  localparam int CONV_W = 17;
  localparam logic signed [CONV_W-1:0] K_Y    = 17'sd2000;
  localparam logic signed [CONV_W-1:0] K_CR_R = 17'sd2742;
  localparam logic signed [CONV_W-1:0] K_CR_G = 17'sd1396;
  localparam logic signed [CONV_W-1:0] K_CB_G = 17'sd672;
  localparam logic signed [CONV_W-1:0] K_CB_B = 17'sd3464;

  // Division by 125 through a reciprocal, exact below the saturation point
  localparam int SAT_LIMIT   = 32000;
  localparam int RECIP_MUL   = 33555;
  localparam int RECIP_SHIFT = 22;

  // Output queue
  localparam int OUT_Q_DEPTH = 4;
  localparam int OUT_Q_PW    = $clog2(OUT_Q_DEPTH);
  localparam int OUT_Q_CW    = $clog2(OUT_Q_DEPTH + 1);

  typedef struct packed {
    logic [NIBBLE_W-1:0] luma;
    logic [NIBBLE_W-1:0] cr;
    logic [NIBBLE_W-1:0] cb;
  } ylpc_pix_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic [CLASS_W-1:0] class_code;
    logic               is_classified;
  } ylpc_result_t;

  typedef struct packed {
    logic [OUT_Q_CW-1:0] level;
    logic                full;
  } ylpc_q_stat_t;

endpackage

// File: rtl/ylpc_ram.sv
module ylpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/ylpc_convert.sv
module ylpc_convert (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  ylpc_pkg::ylpc_pix_t           in_pix,
  input  logic [ylpc_pkg::CLASS_W-1:0]  in_class,
  input  ylpc_pkg::color_bank_t         colors,
  output logic                          out_valid,
  output ylpc_pkg::ylpc_result_t        out_result
);
  import ylpc_pkg::*;

  logic signed [CONV_W-1:0] y_s, dr_s, db_s;
  logic signed [CONV_W-1:0] w_red_nxt, w_green_nxt, w_blue_nxt;
  logic signed [CONV_W-1:0] w_red_r, w_green_r, w_blue_r;
  logic [CLASS_W-1:0]       class_r;
  logic                     valid_r;
  logic [CLASS_W-1:0]       color_idx;
  logic [COLOR_W-1:0]       overlay;

  // Take a scaled channel value to 0..255: floor(w / 125), saturated
  function automatic logic [CHAN_W-1:0] scale_clamp(input logic signed [CONV_W-1:0] w);
    logic [31:0]       prod;
    logic [CHAN_W-1:0] q;
    prod = 32'(w[CONV_W-2:0]) * 32'(RECIP_MUL);
    if (w[CONV_W-1]) begin
      q = '0;
    end else if (32'(w[CONV_W-2:0]) >= 32'(SAT_LIMIT)) begin
      q = '1;
    end else begin
      q = prod[RECIP_SHIFT +: CHAN_W];
    end
    return q;
  endfunction

  // Linear part of the colour conversion
  always_comb begin
    y_s         = $signed({{(CONV_W-NIBBLE_W){1'b0}}, in_pix.luma});
    dr_s        = $signed({{(CONV_W-NIBBLE_W){1'b0}}, in_pix.cr})
                  - $signed({{(CONV_W-NIBBLE_W){1'b0}}, MID_CHROMA});
    db_s        = $signed({{(CONV_W-NIBBLE_W){1'b0}}, in_pix.cb})
                  - $signed({{(CONV_W-NIBBLE_W){1'b0}}, MID_CHROMA});
    w_red_nxt   = K_Y * y_s + K_CR_R * dr_s;
    w_green_nxt = K_Y * y_s - K_CR_G * dr_s - K_CB_G * db_s;
    w_blue_nxt  = K_Y * y_s + K_CB_B * db_s;
  end

  // Hold the scaled sums and the class for the final stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
    w_red_r   <= w_red_nxt;
    w_green_r <= w_green_nxt;
    w_blue_r  <= w_blue_nxt;
    class_r   <= in_class;
  end

  // Pick overlay colour or converted pixel
  always_comb begin
    color_idx = class_r - CLASS_W'(1);
    overlay   = colors[color_idx];
    if (class_r != '0) begin
      out_result.red           = overlay[2*CHAN_W +: CHAN_W];
      out_result.green         = overlay[CHAN_W +: CHAN_W];
      out_result.blue          = overlay[0 +: CHAN_W];
      out_result.class_code    = class_r;
      out_result.is_classified = 1'b1;
    end else begin
      out_result.red           = scale_clamp(w_red_r);
      out_result.green         = scale_clamp(w_green_r);
      out_result.blue          = scale_clamp(w_blue_r);
      out_result.class_code    = '0;
      out_result.is_classified = 1'b0;
    end
  end

  assign out_valid = valid_r;

  a_stage_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid |=> out_valid)
    else $error("converter dropped a pixel between stages");

endmodule

// File: rtl/ylpc_fifo.sv
module ylpc_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  ylpc_pkg::ylpc_result_t push_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output ylpc_pkg::ylpc_result_t out_data,
  output ylpc_pkg::ylpc_q_stat_t stat
);
  import ylpc_pkg::*;

  ylpc_result_t        mem_r [OUT_Q_DEPTH];
  logic [OUT_Q_PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [OUT_Q_CW-1:0] count_r;
  logic                pop;

  function automatic logic [OUT_Q_PW-1:0] ptr_inc(input logic [OUT_Q_PW-1:0] p);
    return (p == OUT_Q_PW'(OUT_Q_DEPTH - 1)) ? '0 : p + OUT_Q_PW'(1);
  endfunction

  assign pop = out_valid && out_ready;

  // Advance pointers and level on push and pop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + OUT_Q_CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - OUT_Q_CW'(1);
      end
    end
  end

  // Store results
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign out_valid  = (count_r != '0);
  assign out_data   = mem_r[rd_ptr_r];
  assign stat.level = count_r;
  assign stat.full  = (count_r == OUT_Q_CW'(OUT_Q_DEPTH));

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!stat.full || pop))
    else $error("result queue overflow");

endmodule

// File: rtl/ycrcb_lut_pixel_classifier_unit.sv
// Channel   | Ports                          | Transaction
// ----------+--------------------------------+---------------------------------------
// input     | in_tvalid/in_tready/in_tdata   | table write (tuser 0) or pixel (tuser 1)
//           | in_tuser                       |
// result    | out_tvalid/out_tready/out_tdata| one classified or converted pixel
//           | out_tuser                      |
// config    | cfg_wr_en/cfg_index/cfg_wr_data| overlay colour write, no wait
//
// One item accepted per cycle while in_tready is high; a pixel's result is visible once it
// passes the registered class table read, the registered conversion sums and the result queue.
// After reset the table is cleared one entry a cycle, and in_tready stays low until the sweep ends.
// A four-entry result queue plus the two stages ahead of it are credited: outside the clear,
// in_tready drops only when four results are in flight or waiting, never on out_tready itself.
module ycrcb_lut_pixel_classifier_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] pixel_byte, [8] odd_column, [9] frame_start, [21:10] table_index,
  // [24:22] table_class, [31:25] zero
  input  logic [31:0] in_tdata,
  // [0] func
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] red, [15:8] green, [23:16] blue, [26:24] class_code, [31:27] zero
  output logic [31:0] out_tdata,
  // [0] is_classified
  output logic        out_tuser,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wr_data
);
  import ylpc_pkg::*;

  typedef struct packed {
    logic [6:0]          pad;
    logic [CLASS_W-1:0]  table_class;
    logic [TABLE_AW-1:0] table_index;
    logic                frame_start;
    logic                odd_column;
    logic [7:0]          pixel_byte;
  } in_word_t;

  in_word_t            in_word;
  logic                accept, pix_accept, wr_accept;
  logic [NIBBLE_W-1:0] luma, nibble, base_cr, base_cb, cr_nxt, cb_nxt;
  logic [NIBBLE_W-1:0] held_cr_r, held_cb_r;
  logic                clearing_r;
  logic [TABLE_AW-1:0] clr_addr_r;
  logic                ram_we;
  logic [TABLE_AW-1:0] ram_waddr;
  logic [CLASS_W-1:0]  ram_wdata, ram_rdata;
  logic                s1_valid_r;
  ylpc_pix_t           s1_pix_r, pix_nxt;
  color_bank_t         color_r;
  logic                s2_valid;
  ylpc_result_t        s2_result, q_data;
  ylpc_q_stat_t        q_stat;
  logic [OUT_Q_CW-1:0] inflight;

  assign in_word    = in_word_t'(in_tdata);
  assign accept     = in_tvalid && in_tready;
  assign pix_accept = accept && (in_tuser == FUNC_PIXEL);
  assign wr_accept  = accept && (in_tuser == FUNC_WRITE);

  // Credit the pipeline stages and the result queue
  assign inflight  = q_stat.level + {{(OUT_Q_CW-1){1'b0}}, s1_valid_r}
                     + {{(OUT_Q_CW-1){1'b0}}, s2_valid};
  assign in_tready = !clearing_r && (inflight < OUT_Q_CW'(OUT_Q_DEPTH));

  // Update the held chroma: frame start first, then this pixel's nibble
  always_comb begin
    luma    = in_word.pixel_byte[7:4];
    nibble  = in_word.pixel_byte[3:0];
    base_cr = in_word.frame_start ? MID_CHROMA : held_cr_r;
    base_cb = in_word.frame_start ? MID_CHROMA : held_cb_r;
    cr_nxt  = in_word.odd_column ? base_cr : nibble;
    cb_nxt  = in_word.odd_column ? nibble : base_cb;
    pix_nxt = '{luma: luma, cr: cr_nxt, cb: cb_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cr_r  <= MID_CHROMA;
      held_cb_r  <= MID_CHROMA;
      s1_valid_r <= 1'b0;
    end else begin
      if (pix_accept) begin
        held_cr_r <= cr_nxt;
        held_cb_r <= cb_nxt;
      end
      s1_valid_r <= pix_accept;
    end
    if (pix_accept) begin
      s1_pix_r <= pix_nxt;
    end
  end

  // Sweep the class table to zero after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + TABLE_AW'(1);
      if (clr_addr_r == TABLE_AW'(TABLE_DEPTH - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  assign ram_we    = clearing_r || wr_accept;
  assign ram_waddr = clearing_r ? clr_addr_r : in_word.table_index;
  assign ram_wdata = clearing_r ? '0 : in_word.table_class;

  ylpc_ram #(
    .WIDTH (CLASS_W),
    .DEPTH (TABLE_DEPTH)
  ) u_class_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (pix_accept),
    .raddr ({pix_nxt.luma, pix_nxt.cr, pix_nxt.cb}),
    .rdata (ram_rdata)
  );

  // Overlay colour registers; unused indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r <= COLOR_RESET;
    end else if (cfg_wr_en && (cfg_index <= CFG_CLASS7_COLOR)) begin
      color_r[cfg_index - CFG_CLASS1_COLOR] <= cfg_wr_data;
    end
  end

  ylpc_convert u_convert (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (s1_valid_r),
    .in_pix     (s1_pix_r),
    .in_class   (ram_rdata),
    .colors     (color_r),
    .out_valid  (s2_valid),
    .out_result (s2_result)
  );

  ylpc_fifo u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s2_valid),
    .push_data (s2_result),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (q_data),
    .stat      (q_stat)
  );

  assign out_tdata = {5'd0, q_data.class_code, q_data.blue, q_data.green, q_data.red};
  assign out_tuser = q_data.is_classified;

  a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !in_tready)
    else $error("input taken during table clear");

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    inflight <= OUT_Q_CW'(OUT_Q_DEPTH))
    else $error("more results in flight than queue space");

  a_pixel_reaches_s1: assert property (@(posedge clk) disable iff (!rst_n)
    pix_accept |=> s1_valid_r)
    else $error("accepted pixel did not reach the lookup stage");

endmodule
